FILE: sv/bencode_stream_tokenizer_defines.svh
// Assertion macros used by the tokenizer RTL.
`ifndef BENCODE_STREAM_TOKENIZER_DEFINES_SVH
`define BENCODE_STREAM_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bst assertion failed");
// next-cycle implication
`define BST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bst assertion failed");
`else
`define BST_ASSERT_IMP(label, clk, rst, ante, cons)
`define BST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/bst_pkg.sv
// Types and constants for the bencode stream tokenizer.
package bst_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic signed [63:0] value;
      logic [7:0]         payload_byte;
      logic               string_end;
      logic               is_key;
      logic [5:0]         nest_depth;
      logic [2:0]         error_code;
      logic               doc_done;
   } rsp_type;

   // event codes
   localparam logic [3:0] EV_ABSORBED = 4'd0;
   localparam logic [3:0] EV_LENGTH   = 4'd1;
   localparam logic [3:0] EV_PAYLOAD  = 4'd2;
   localparam logic [3:0] EV_INTEGER  = 4'd3;
   localparam logic [3:0] EV_LIST     = 4'd4;
   localparam logic [3:0] EV_DICT     = 4'd5;
   localparam logic [3:0] EV_CLOSE    = 4'd6;
   localparam logic [3:0] EV_ERROR    = 4'd7;
   localparam logic [3:0] EV_IGNORED  = 4'd8;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd1;
   localparam logic [2:0] ERR_INVALID    = 3'd2;
   localparam logic [2:0] ERR_TRAILING   = 3'd3;
   localparam logic [2:0] ERR_TOO_DEEP   = 3'd4;

   // syntax characters
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // largest accumulator that can still take one more digit
   localparam logic [63:0] CUT_TENTH = 64'd922337203685477580;

endpackage

FILE: sv/bst_ram.sv
// Generic single-port-write, registered-read RAM.
module bst_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 31,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bencode_stream_tokenizer.sv
// Bencode stream tokenizer: one event per input byte.
//
// Usage
//   req channel: one transaction per document byte (data_byte, end_of_input).
//   rsp channel: exactly one event transaction per accepted byte, in order.
//   Bytes pass an input register, then one pass of parse logic, then the
//   result register. One byte per cycle is sustained while rsp_ready is high;
//   the limit is the single parse step (the x10 accumulate and the one stack
//   push or pop per byte).
//   Container stack: top entry in flops, the rest in a RAM with registered
//   read; the entry under the top is always prefetched so a close need not
//   wait on the RAM read. No clearing pass is needed after reset.
//   Reset: synchronous; parser expects a top-level value at depth 0 with no
//   error. Errors are sticky, and after end_of_input only reset re-arms.
//   Stall: if rsp_ready is low, the result register holds; one more byte
//   may sit in the input register, then req_ready drops.
// While rsp_ready stays high the design is full throughput: no bubbles, no dead cycles.
`include "bencode_stream_tokenizer_defines.svh"

module bencode_stream_tokenizer #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bst_pkg::rsp_type rsp_data
);

   localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
   localparam int RAM_DEPTH = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
   localparam int RAM_AW   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // digit tracking
   localparam logic [1:0] DIG_NONE = 2'd0;
   localparam logic [1:0] DIG_ZERO = 2'd1;
   localparam logic [1:0] DIG_MORE = 2'd2;

   typedef enum logic [2:0] {
      MODE_VALUE,
      MODE_INT,
      MODE_LEN,
      MODE_PAYLOAD,
      MODE_DONE,
      MODE_ERR
   } mode_type;

   // handshake / pipeline
   logic             in_valid_ff;
   bst_pkg::req_type in_data_ff;
   logic             rsp_valid_ff;
   bst_pkg::rsp_type rsp_data_ff;
   logic             advance;

   // parser state
   mode_type           mode_ff, mode_in;
   logic [63:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [1:0]         dsi_ff, dsi_in;
   logic [62:0]        sbl_ff, sbl_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               tkind_ff, tkind_in;   // top entry: 1 = dict
   logic               tkey_ff, tkey_in;     // top entry: dict expects key
   logic [2:0]         sticky_ff, sticky_in;
   bst_pkg::rsp_type   rsp_in;

   // stack RAM
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic [1:0]        wr_data;
   logic [RAM_AW-1:0] rd_addr;
   logic [1:0]        rd_data;
   logic              byp_ff;
   logic [1:0]        byp_data_ff;
   logic [1:0]        below;
   logic [DEPTH_W-1:0] depth_next;
   logic [DEPTH_W:0]   depth_m2;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry just under the top, with write-to-read bypass
   assign below = byp_ff ? byp_data_ff : rd_data;

   // parse step
   always_comb begin
      logic [7:0]  b;
      logic        last;
      logic        is_digit;
      logic [3:0]  dval;
      logic [3:0]  lim;
      logic        ovf;
      logic [63:0] acc_x10;
      logic        top_dict;
      logic        key_pos;
      logic        top_dict_n;
      logic        key_pos_n;
      logic        fin;
      logic [2:0]  err;
      logic [3:0]  ev;
      logic [63:0] val;
      logic [7:0]  pb;
      logic        send;
      logic        key;
      logic        done;

      b        = in_data_ff.data_byte;
      last     = in_data_ff.end_of_input;
      is_digit = b inside {[bst_pkg::CHAR_ZERO:bst_pkg::CHAR_NINE]};
      dval     = 4'(b - bst_pkg::CHAR_ZERO);
      lim      = (mode_ff == MODE_INT && neg_ff) ? 4'd8 : 4'd7;
      ovf      = (acc_ff > bst_pkg::CUT_TENTH) ||
                 ((acc_ff == bst_pkg::CUT_TENTH) && (dval > lim));
      acc_x10  = (acc_ff << 3) + (acc_ff << 1) + 64'(dval);
      top_dict = (depth_ff != '0) && tkind_ff;
      key_pos  = top_dict && tkey_ff;

      mode_in   = mode_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      dsi_in    = dsi_ff;
      sbl_in    = sbl_ff;
      depth_in  = depth_ff;
      tkind_in  = tkind_ff;
      tkey_in   = tkey_ff;
      sticky_in = sticky_ff;
      wr_en     = 1'b0;
      fin       = 1'b0;
      err       = bst_pkg::ERR_NONE;
      ev        = bst_pkg::EV_ABSORBED;
      val       = '0;
      pb        = '0;
      send      = 1'b0;
      key       = 1'b0;
      done      = 1'b0;

      case (mode_ff)
         MODE_DONE: begin
            err = bst_pkg::ERR_TRAILING;
         end
         MODE_VALUE: begin
            if (b == bst_pkg::CHAR_E) begin
               if (depth_ff != '0 && (!top_dict || key_pos)) begin
                  depth_in = depth_ff - DEPTH_W'(1);
                  tkind_in = below[1];
                  tkey_in  = below[0];
                  ev       = bst_pkg::EV_CLOSE;
                  fin      = 1'b1;
               end else begin
                  err = bst_pkg::ERR_INVALID;
               end
            end else if (is_digit) begin
               mode_in = MODE_LEN;
               acc_in  = 64'(dval);
               dsi_in  = (b == bst_pkg::CHAR_ZERO) ? DIG_ZERO : DIG_MORE;
            end else if (key_pos) begin
               err = bst_pkg::ERR_INVALID;
            end else if (b == bst_pkg::CHAR_I) begin
               mode_in = MODE_INT;
               acc_in  = '0;
               neg_in  = 1'b0;
               dsi_in  = DIG_NONE;
            end else if (b == bst_pkg::CHAR_L || b == bst_pkg::CHAR_D) begin
               if (depth_ff >= DEPTH_W'(STACK_DEPTH)) begin
                  err = bst_pkg::ERR_TOO_DEEP;
               end else begin
                  // old top moves into the RAM
                  wr_en    = (depth_ff != '0);
                  tkind_in = (b == bst_pkg::CHAR_D);
                  tkey_in  = (b == bst_pkg::CHAR_D);
                  depth_in = depth_ff + DEPTH_W'(1);
                  ev = (b == bst_pkg::CHAR_D) ? bst_pkg::EV_DICT : bst_pkg::EV_LIST;
               end
            end else begin
               err = bst_pkg::ERR_INVALID;
            end
         end
         MODE_INT: begin
            if (b == bst_pkg::CHAR_MINUS && !neg_ff && dsi_ff == DIG_NONE) begin
               neg_in = 1'b1;
            end else if (is_digit) begin
               if ((neg_ff && dsi_ff == DIG_NONE && dval == 4'd0) ||
                   dsi_ff == DIG_ZERO || ovf) begin
                  err = bst_pkg::ERR_INVALID;
               end else begin
                  acc_in = acc_x10;
                  dsi_in = (dsi_ff == DIG_NONE && dval == 4'd0) ? DIG_ZERO : DIG_MORE;
               end
            end else if (b == bst_pkg::CHAR_E && dsi_ff != DIG_NONE) begin
               val = neg_ff ? (64'd0 - acc_ff) : acc_ff;
               ev  = bst_pkg::EV_INTEGER;
               fin = 1'b1;
            end else begin
               err = bst_pkg::ERR_INVALID;
            end
         end
         MODE_LEN: begin
            if (is_digit) begin
               if (dsi_ff == DIG_ZERO || ovf) begin
                  err = bst_pkg::ERR_INVALID;
               end else begin
                  acc_in = acc_x10;
                  dsi_in = DIG_MORE;
               end
            end else if (b == bst_pkg::CHAR_COLON) begin
               ev  = bst_pkg::EV_LENGTH;
               val = acc_ff;
               key = key_pos;
               if (acc_ff == '0) begin
                  send = 1'b1;
                  fin  = 1'b1;
               end else begin
                  sbl_in  = acc_ff[62:0];
                  mode_in = MODE_PAYLOAD;
               end
            end else begin
               err = bst_pkg::ERR_INVALID;
            end
         end
         MODE_PAYLOAD: begin
            ev  = bst_pkg::EV_PAYLOAD;
            pb  = b;
            key = key_pos;
            if (sbl_ff != '0) begin
               sbl_in = sbl_ff - 63'd1;
            end
            if (sbl_in == '0) begin
               send = 1'b1;
               fin  = 1'b1;
            end
         end
         default: begin
            ev = bst_pkg::EV_IGNORED;
         end
      endcase

      // value finished: top-level completes, or dict flips key/value slot
      if (fin) begin
         if (depth_in == '0) begin
            mode_in = MODE_DONE;
            done    = 1'b1;
         end else begin
            mode_in = MODE_VALUE;
            if (tkind_in) begin
               tkey_in = ~tkey_in;
            end
         end
      end

      // truncated document
      top_dict_n = (depth_in != '0) && tkind_in;
      key_pos_n  = top_dict_n && tkey_in;
      if (err == bst_pkg::ERR_NONE && last) begin
         case (mode_in)
            MODE_VALUE: begin
               err = (depth_in == '0 || (top_dict_n && !key_pos_n)) ?
                     bst_pkg::ERR_INCOMPLETE : bst_pkg::ERR_INVALID;
            end
            MODE_INT: begin
               err = (dsi_in == DIG_NONE && !neg_in) ?
                     bst_pkg::ERR_INCOMPLETE : bst_pkg::ERR_INVALID;
            end
            MODE_LEN:     err = bst_pkg::ERR_INVALID;
            MODE_PAYLOAD: err = bst_pkg::ERR_INCOMPLETE;
            default:      err = bst_pkg::ERR_NONE;
         endcase
      end

      if (err != bst_pkg::ERR_NONE) begin
         sticky_in = err;
         mode_in   = MODE_ERR;
         ev        = bst_pkg::EV_ERROR;
         val       = '0;
         pb        = '0;
         send      = 1'b0;
         key       = 1'b0;
         done      = 1'b0;
      end

      rsp_in.event_res    = ev;
      rsp_in.value        = val;
      rsp_in.payload_byte = pb;
      rsp_in.string_end   = send;
      rsp_in.is_key       = key;
      rsp_in.nest_depth   = 6'(depth_in);
      rsp_in.error_code   = sticky_in;
      rsp_in.doc_done     = done;
   end

   // stack RAM addressing: RAM holds entries 0 .. depth-2, read port
   // points at the entry under the (next) top, or at 0 below depth 2
   assign wr_addr    = RAM_AW'(depth_ff - DEPTH_W'(1));
   assign wr_data    = {tkind_ff, tkey_ff};
   assign depth_next = advance ? depth_in : depth_ff;
   assign depth_m2   = {1'b0, depth_next} - (DEPTH_W + 1)'(2);
   assign rd_addr    = ({1'b0, depth_next} >= (DEPTH_W + 1)'(2)) ?
                       RAM_AW'(depth_m2) : '0;

   bst_ram #(
      .WIDTH (2),
      .DEPTH (RAM_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (advance && wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_VALUE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         dsi_ff       <= DIG_NONE;
         sbl_ff       <= '0;
         depth_ff     <= '0;
         tkind_ff     <= 1'b0;
         tkey_ff      <= 1'b0;
         sticky_ff    <= bst_pkg::ERR_NONE;
         byp_ff       <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff   <= mode_in;
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            dsi_ff    <= dsi_in;
            sbl_ff    <= sbl_in;
            depth_ff  <= depth_in;
            tkind_ff  <= tkind_in;
            tkey_ff   <= tkey_in;
            sticky_ff <= sticky_in;
         end
         byp_ff <= advance && wr_en && (wr_addr == rd_addr);
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
      byp_data_ff <= wr_data;
   end

   `BST_ASSERT_IMP(a_done_at_top, clock, reset, mode_ff == MODE_DONE, depth_ff == '0)
   `BST_ASSERT_IMP(a_err_sticky, clock, reset, mode_ff == MODE_ERR, sticky_ff != bst_pkg::ERR_NONE)
   `BST_ASSERT_IMP(a_ok_no_err, clock, reset, mode_ff != MODE_ERR, sticky_ff == bst_pkg::ERR_NONE)
   `BST_ASSERT_IMP(a_payload_left, clock, reset, mode_ff == MODE_PAYLOAD, sbl_ff != '0)
   `BST_ASSERT_NXT(a_ignored_after_err, clock, reset, advance && mode_ff == MODE_ERR, rsp_valid_ff && rsp_data_ff.event_res == bst_pkg::EV_IGNORED)
   `BST_ASSERT_IMP(a_err_event_code, clock, reset, rsp_valid_ff && rsp_data_ff.event_res == bst_pkg::EV_ERROR, rsp_data_ff.error_code != bst_pkg::ERR_NONE)

endmodule
